@@ rtl/isc_pkg.sv @@
// ----------------------------------------------------------------------------
// isc_pkg
// Shared widths, defaults and sequencer states for the insertion sorter.
// ----------------------------------------------------------------------------
package isc_pkg;

  // Default store depth.
  localparam int MAX_ELEMS_DEF = 64;

  // Fixed field widths of the streams.
  localparam int VALUE_W = 32;
  localparam int STEP_W  = 7;
  localparam int SHIFT_W = 11;
  localparam int CMPC_W  = 11;

  // Output tdata: payload bits, rounded up to whole bytes.
  localparam int M_PAYLOAD_W = VALUE_W + STEP_W + SHIFT_W + CMPC_W + 1;
  localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_KEY,
    ST_RD_PREV,
    ST_CMP,
    ST_STORE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

@@ rtl/isc_mem.sv @@
// ----------------------------------------------------------------------------
// isc_mem
// Element store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module isc_mem
  import isc_pkg::*;
#(
  parameter int DEPTH = MAX_ELEMS_DEF,
  parameter int AW    = $clog2(MAX_ELEMS_DEF)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/isc_cmp.sv @@
// ----------------------------------------------------------------------------
// isc_cmp
// Shared key comparator: says whether the key must move ahead of the other
// element in the selected order.
// ----------------------------------------------------------------------------
module isc_cmp
  import isc_pkg::*;
(
  input  logic [VALUE_W-1:0] key,
  input  logic [VALUE_W-1:0] other,
  input  logic               descending,
  output logic               key_first
);

  logic signed [VALUE_W-1:0] key_s;
  logic signed [VALUE_W-1:0] other_s;

  assign key_s   = key;
  assign other_s = other;

  // Strict compare keeps equal keys in arrival order.
  assign key_first = descending ? (key_s > other_s) : (key_s < other_s);

endmodule

@@ rtl/insertion_sort_with_counts.sv @@
// ----------------------------------------------------------------------------
// insertion_sort_with_counts
// Collects a set of signed values, insertion-sorts it and streams it out
// together with step, shift and comparison counts.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one value per transaction; s_tlast closes a set.
//   s_tready stays high while loading. Values beyond MAX_ELEMS are
//   dropped and the overflow bit of that set's results is raised.
//   After the closing transaction the block sorts the set with one shared
//   comparator and one memory read port. Inserting an element reads the key,
//   reads the element below it, runs one compare step per key comparison,
//   shifting up each element that the key moves ahead of, and stores the key.
//   The results then leave on the master stream, each read from the store and
//   then offered as a transaction, so the next is not read before the current
//   one is taken; m_tlast marks the last one. A stall on m_tready holds the current result.
//   s_tready is low from the closing transaction until the last result of
//   the set is taken. The cfg channel is always ready and writes the
//   descending bit; write it only while no set is in flight.
//   Reset (rst, synchronous) clears the set, the counts, the overflow flag
//   and the descending bit. The store itself has no reset.
// ----------------------------------------------------------------------------
module insertion_sort_with_counts
  import isc_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [VALUE_W-1:0]   s_tdata,   // [31:0] value
  input  logic                 s_tlast,   // last_in
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] sorted_value, [38:32] step_count,
                                          // [49:39] shift_count,
                                          // [60:50] compare_count, [61] overflow,
                                          // [63:62] zero
  output logic                 m_tlast,   // last_out
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data   // descending
);

  localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CW = $clog2(MAX_ELEMS + 1);

  state_t state, state_next;

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               overflow_flag;
  logic               descending;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      pos;
  logic [CW-1:0]      emit_idx;
  logic [VALUE_W-1:0] key;
  logic [STEP_W-1:0]  steps_total;
  logic [SHIFT_W-1:0] shifts_total;
  logic [CMPC_W-1:0]  compares_total;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  logic               key_first;
  logic               in_xfer;
  logic               out_xfer;
  logic               store_full;
  logic               more_keys;

  // Element store and shared comparator.
  isc_mem #(
    .DEPTH (MAX_ELEMS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  isc_cmp u_cmp (
    .key        (key),
    .other      (mem_rdata),
    .descending (descending),
    .key_first  (key_first)
  );

  // Handshake decodes and small helpers.
  assign in_xfer    = s_tvalid && s_tready;
  assign out_xfer   = m_tvalid && m_tready;
  assign store_full = (count == CW'(MAX_ELEMS));
  assign count_next = store_full ? count : count + CW'(1);
  assign more_keys  = (CW'(idx) + CW'(1)) < count;
  assign cfg_ready  = 1'b1;

  // Output payload comes straight from the held read data and the totals.
  assign m_tdata = {{(M_TDATA_W - M_PAYLOAD_W){1'b0}}, overflow_flag, compares_total,
                    shifts_total, steps_total, mem_rdata};
  assign m_tlast = (emit_idx + CW'(1)) == count;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_xfer && s_tlast) begin
          state_next = (count_next > CW'(1)) ? ST_RD_KEY : ST_EMIT_RD;
        end
      end
      ST_RD_KEY:  state_next = ST_RD_PREV;
      ST_RD_PREV: state_next = ST_CMP;
      ST_CMP: begin
        if (!key_first || pos == AW'(1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE:   state_next = more_keys ? ST_RD_KEY : ST_EMIT_RD;
      ST_EMIT_RD: state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_xfer) begin
          state_next = m_tlast ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:    state_next = ST_LOAD;
    endcase
  end

  // Output and memory port decode.
  always_comb begin
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = key;
    mem_re    = 1'b0;
    mem_raddr = idx;
    unique case (state)
      ST_LOAD: begin
        s_tready  = 1'b1;
        mem_we    = in_xfer && !store_full;
        mem_waddr = count[AW-1:0];
        mem_wdata = s_tdata;
      end
      ST_RD_KEY: begin
        mem_re    = 1'b1;
        mem_raddr = idx;
      end
      ST_RD_PREV: begin
        mem_re    = 1'b1;
        mem_raddr = pos - AW'(1);
      end
      ST_CMP: begin
        // Shift the compared element up and fetch the next one below.
        mem_we    = key_first;
        mem_waddr = pos;
        mem_wdata = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = pos - AW'(2);
      end
      ST_STORE: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
        mem_wdata = key;
      end
      ST_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = emit_idx[AW-1:0];
      end
      ST_EMIT_OUT: begin
        m_tvalid  = 1'b1;
      end
      default: begin
        s_tready  = 1'b0;
      end
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      count          <= '0;
      overflow_flag  <= 1'b0;
      descending     <= 1'b0;
      steps_total    <= '0;
      shifts_total   <= '0;
      compares_total <= '0;
      idx            <= '0;
      pos            <= '0;
      emit_idx       <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        descending <= cfg_data;
      end

      unique case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            count <= count_next;
            if (store_full) begin
              overflow_flag <= 1'b1;
            end
            if (s_tlast) begin
              steps_total    <= '0;
              shifts_total   <= '0;
              compares_total <= '0;
              idx            <= AW'(1);
              emit_idx       <= '0;
            end
          end
        end
        ST_RD_KEY: begin
          pos <= idx;
        end
        ST_RD_PREV: begin
          pos <= pos;
        end
        ST_CMP: begin
          compares_total <= compares_total + CMPC_W'(1);
          if (key_first) begin
            pos          <= pos - AW'(1);
            shifts_total <= shifts_total + SHIFT_W'(1);
          end
        end
        ST_STORE: begin
          steps_total <= steps_total + STEP_W'(2);
          idx         <= idx + AW'(1);
        end
        ST_EMIT_RD: begin
          emit_idx <= emit_idx;
        end
        ST_EMIT_OUT: begin
          if (out_xfer) begin
            emit_idx <= emit_idx + CW'(1);
            if (m_tlast) begin
              count         <= '0;
              overflow_flag <= 1'b0;
            end
          end
        end
        default: begin
          pos <= pos;
        end
      endcase
    end
  end

  // Key register loads from the read of the element being inserted.
  always_ff @(posedge clk) begin
    if (state == ST_RD_PREV) begin
      key <= mem_rdata;
    end
  end

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMS))
    else $error("element count exceeds store depth");

  // A comparison always has an element below the insertion point.
  a_cmp_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (pos != '0))
    else $error("comparison issued at the front of the store");

  // Every shift is also a comparison.
  a_shift_le_cmp: assert property (@(posedge clk) disable iff (rst)
    shifts_total <= SHIFT_W'(compares_total))
    else $error("shift count exceeds comparison count");

  // Taking the last result starts a fresh, empty set.
  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_tlast) |=> (count == '0 && !overflow_flag && state == ST_LOAD))
    else $error("set not cleared after the last result");

  // Sorting only begins on a set that holds at least two values.
  a_sort_size: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_KEY) |-> (CW'(idx) < count))
    else $error("insertion index beyond the fill count");

endmodule
